FILE: hdl/kmcc_pkg.sv
// types, codes and constants shared by the knob menu countdown controller
package kmcc_pkg;

    localparam int TICK_W    = 16;
    localparam int HOURS_W   = 7;
    localparam int MINUTES_W = 6;
    localparam int TEMP_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [TEMP_W-1:0]    TEMP_MAX    = 7'd99;
    localparam logic [TEMP_W-1:0]    TEMP_RESET  = 7'd50;
    localparam logic [HOURS_W-1:0]   HOURS_CAP   = 7'd99;
    localparam logic [MINUTES_W-1:0] MINUTES_TOP = 6'd59;
    localparam logic [TICK_W-1:0]    TICKS_RESET = 16'd50;
    localparam logic [HOURS_W-1:0]   MAX_HOURS_RESET = 7'd12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOURS       = 1'd1;

    // encoder step codes
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    // codes seen on the result ports
    localparam logic [1:0] UI_IDLE  = 2'd0;
    localparam logic [1:0] UI_TEMP  = 2'd1;
    localparam logic [1:0] UI_HOURS = 2'd2;

    localparam logic [2:0] DB_NONE           = 3'd0;
    localparam logic [2:0] DB_MAYBE_PRESSED  = 3'd1;
    localparam logic [2:0] DB_PRESSED        = 3'd2;
    localparam logic [2:0] DB_MAYBE_RELEASED = 3'd3;
    localparam logic [2:0] DB_RELEASED       = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_TEMP  = 3'b010,
        MODE_HOURS = 3'b100
    } mode_t;

    typedef enum logic [4:0] {
        PH_NONE           = 5'b00001,
        PH_MAYBE_PRESSED  = 5'b00010,
        PH_PRESSED        = 5'b00100,
        PH_MAYBE_RELEASED = 5'b01000,
        PH_RELEASED       = 5'b10000
    } phase_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            MODE_IDLE:  c = UI_IDLE;
            MODE_TEMP:  c = UI_TEMP;
            MODE_HOURS: c = UI_HOURS;
            default:    c = UI_IDLE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] c;
        case (p)
            PH_NONE:           c = DB_NONE;
            PH_MAYBE_PRESSED:  c = DB_MAYBE_PRESSED;
            PH_PRESSED:        c = DB_PRESSED;
            PH_MAYBE_RELEASED: c = DB_MAYBE_RELEASED;
            PH_RELEASED:       c = DB_RELEASED;
            default:           c = DB_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/knob_menu_countdown_controller_unit.sv
// Knob menu countdown controller: takes one 50 Hz tick item per cycle (button level and
// encoder step), counts an hours:minutes countdown down once every ticks_per_count ticks
// while the menu is idle, debounces the button, steps the menu on each debounced release
// and lets the encoder adjust the selected value. Each item is registered on entry and its
// result, the state after that tick, is registered on exit: the result reaches the outputs
// from the result register once the item leaves the entry register, and a new item can be
// accepted in every cycle while the result register drains. The input stalls only while an
// item waits in the entry register behind a result that is held by out_stall.
// Configuration writes are always accepted and take effect on the next item.
module knob_menu_countdown_controller_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // tick items
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                button_level,
    input  logic [1:0]                          encoder_step,
    // results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          ui_mode,
    output logic [kmcc_pkg::TEMP_W-1:0]         target_temp,
    output logic [kmcc_pkg::HOURS_W-1:0]        hours_left,
    output logic [kmcc_pkg::MINUTES_W-1:0]      minutes_left,
    output logic [2:0]                          debounce_phase,
    output logic                                countdown_running,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kmcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kmcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [kmcc_pkg::TICK_W-1:0]    ticks_per_count_reg;
    logic [kmcc_pkg::HOURS_W-1:0]   max_hours_reg;

    // input stage
    logic                           s1_valid_reg;
    logic                           s1_button_reg;
    logic [1:0]                     s1_step_reg;

    // block state
    logic [kmcc_pkg::TICK_W-1:0]    tick_phase_reg;
    logic [kmcc_pkg::TICK_W-1:0]    tick_phase_next;
    kmcc_pkg::phase_t               button_phase_reg;
    kmcc_pkg::phase_t               button_phase_next;
    kmcc_pkg::mode_t                mode_reg;
    kmcc_pkg::mode_t                mode_next;
    logic [kmcc_pkg::TEMP_W-1:0]    temp_setting_reg;
    logic [kmcc_pkg::TEMP_W-1:0]    temp_setting_next;
    logic [kmcc_pkg::HOURS_W-1:0]   hours_count_reg;
    logic [kmcc_pkg::HOURS_W-1:0]   hours_count_next;
    logic [kmcc_pkg::MINUTES_W-1:0] minutes_count_reg;
    logic [kmcc_pkg::MINUTES_W-1:0] minutes_count_next;

    // result register
    logic                           out_valid_reg;
    logic [1:0]                     ui_mode_reg;
    logic [kmcc_pkg::TEMP_W-1:0]    target_temp_reg;
    logic [kmcc_pkg::HOURS_W-1:0]   hours_left_reg;
    logic [kmcc_pkg::MINUTES_W-1:0] minutes_left_reg;
    logic [2:0]                     debounce_phase_reg;
    logic                           countdown_running_reg;

    logic                           advance;
    logic                           s1_fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [kmcc_pkg::HOURS_W-1:0]   hours_limit;
        logic [kmcc_pkg::HOURS_W-1:0]   hours_cd;
        logic [kmcc_pkg::MINUTES_W-1:0] minutes_cd;
        logic [kmcc_pkg::TICK_W:0]      phase_inc;

        hours_limit = (max_hours_reg < kmcc_pkg::HOURS_CAP) ? max_hours_reg
                                                            : kmcc_pkg::HOURS_CAP;

        // countdown, only on the phase-zero tick while idle
        hours_cd   = hours_count_reg;
        minutes_cd = minutes_count_reg;
        if ((tick_phase_reg == '0) && (mode_reg == kmcc_pkg::MODE_IDLE))
        begin
            if (minutes_count_reg != '0)
            begin
                minutes_cd = minutes_count_reg - 1'b1;
            end
            else if (hours_count_reg != '0)
            begin
                minutes_cd = kmcc_pkg::MINUTES_TOP;
                hours_cd   = hours_count_reg - 1'b1;
            end
        end

        // debounce
        case (button_phase_reg)
            kmcc_pkg::PH_NONE:
                button_phase_next = s1_button_reg ? kmcc_pkg::PH_MAYBE_PRESSED
                                                  : kmcc_pkg::PH_NONE;
            kmcc_pkg::PH_MAYBE_PRESSED:
                button_phase_next = s1_button_reg ? kmcc_pkg::PH_PRESSED
                                                  : kmcc_pkg::PH_NONE;
            kmcc_pkg::PH_PRESSED:
                button_phase_next = s1_button_reg ? kmcc_pkg::PH_PRESSED
                                                  : kmcc_pkg::PH_MAYBE_RELEASED;
            kmcc_pkg::PH_MAYBE_RELEASED:
                button_phase_next = s1_button_reg ? kmcc_pkg::PH_PRESSED
                                                  : kmcc_pkg::PH_RELEASED;
            default:
                button_phase_next = s1_button_reg ? kmcc_pkg::PH_MAYBE_PRESSED
                                                  : kmcc_pkg::PH_NONE;
        endcase

        // menu steps on a debounced release
        mode_next = mode_reg;
        if (button_phase_next == kmcc_pkg::PH_RELEASED)
        begin
            case (mode_reg)
                kmcc_pkg::MODE_IDLE: mode_next = kmcc_pkg::MODE_TEMP;
                kmcc_pkg::MODE_TEMP: mode_next = kmcc_pkg::MODE_HOURS;
                default:             mode_next = kmcc_pkg::MODE_IDLE;
            endcase
        end

        // encoder adjusts the selected value, code three is no step
        temp_setting_next  = temp_setting_reg;
        hours_count_next   = hours_cd;
        minutes_count_next = minutes_cd;
        if (s1_step_reg == kmcc_pkg::STEP_UP)
        begin
            if (mode_next == kmcc_pkg::MODE_TEMP)
            begin
                if (temp_setting_reg < kmcc_pkg::TEMP_MAX)
                    temp_setting_next = temp_setting_reg + 1'b1;
            end
            else if (mode_next == kmcc_pkg::MODE_HOURS)
            begin
                if (hours_cd < hours_limit)
                    hours_count_next = hours_cd + 1'b1;
            end
        end
        else if (s1_step_reg == kmcc_pkg::STEP_DOWN)
        begin
            if (mode_next == kmcc_pkg::MODE_TEMP)
            begin
                if (temp_setting_reg != '0)
                    temp_setting_next = temp_setting_reg - 1'b1;
            end
            else if (mode_next == kmcc_pkg::MODE_HOURS)
            begin
                if (hours_cd != '0)
                    hours_count_next = hours_cd - 1'b1;
            end
        end

        // a count of zero wraps every tick, as does a count lowered below the phase
        phase_inc = {1'b0, tick_phase_reg} + 1'b1;
        if (phase_inc >= {1'b0, ticks_per_count_reg})
            tick_phase_next = '0;
        else
            tick_phase_next = phase_inc[kmcc_pkg::TICK_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_count_reg <= kmcc_pkg::TICKS_RESET;
            max_hours_reg       <= kmcc_pkg::MAX_HOURS_RESET;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            tick_phase_reg      <= '0;
            button_phase_reg    <= kmcc_pkg::PH_NONE;
            mode_reg            <= kmcc_pkg::MODE_IDLE;
            temp_setting_reg    <= kmcc_pkg::TEMP_RESET;
            hours_count_reg     <= '0;
            minutes_count_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    kmcc_pkg::CFG_TICKS_PER_COUNT: ticks_per_count_reg <= cfg_data;
                    kmcc_pkg::CFG_MAX_HOURS:
                        max_hours_reg <= cfg_data[kmcc_pkg::HOURS_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= s1_valid_reg;

            if (s1_fire)
            begin
                tick_phase_reg    <= tick_phase_next;
                button_phase_reg  <= button_phase_next;
                mode_reg          <= mode_next;
                temp_setting_reg  <= temp_setting_next;
                hours_count_reg   <= hours_count_next;
                minutes_count_reg <= minutes_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_button_reg <= button_level;
            s1_step_reg   <= encoder_step;
        end
        if (s1_fire)
        begin
            ui_mode_reg           <= kmcc_pkg::mode_code(mode_next);
            target_temp_reg       <= temp_setting_next;
            hours_left_reg        <= hours_count_next;
            minutes_left_reg      <= minutes_count_next;
            debounce_phase_reg    <= kmcc_pkg::phase_code(button_phase_next);
            countdown_running_reg <= (hours_count_next != '0) || (minutes_count_next != '0);
        end
    end

    assign out_valid         = out_valid_reg;
    assign ui_mode           = ui_mode_reg;
    assign target_temp       = target_temp_reg;
    assign hours_left        = hours_left_reg;
    assign minutes_left      = minutes_left_reg;
    assign debounce_phase    = debounce_phase_reg;
    assign countdown_running = countdown_running_reg;

`ifndef SYNTHESIS
    // the input side only waits on a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a held result");

    a_minutes_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (minutes_left_reg <= kmcc_pkg::MINUTES_TOP))
        else $error("minutes out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (target_temp_reg <= kmcc_pkg::TEMP_MAX))
        else $error("temperature out of range");

    // menu state only moves when an item is processed
    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(mode_reg))
        else $error("mode changed without an item");
`endif

endmodule

FILE: tb/kmcc_checker.sv
// checker for the knob menu countdown controller: predicts each tick's status and compares
`timescale 1ns / 1ps
module kmcc_checker
    import kmcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  button_level,
    input  logic [1:0]            encoder_step,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [1:0]            ui_mode,
    input  logic [TEMP_W-1:0]     target_temp,
    input  logic [HOURS_W-1:0]    hours_left,
    input  logic [MINUTES_W-1:0]  minutes_left,
    input  logic [2:0]            debounce_phase,
    input  logic                  countdown_running,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    checked,
    output int                    menu_moves,
    output int                    countdown_steps
);

    typedef struct packed {
        logic [1:0]           mode;
        logic [TEMP_W-1:0]    temp;
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [2:0]           phase;
        logic                 running;
    } status_t;

    status_t due_status[$];

    logic [TICK_W-1:0]    ticks_per_count;
    logic [HOURS_W-1:0]   max_hours;
    logic [TICK_W-1:0]    tick_phase;
    logic [2:0]           button_phase;
    logic [1:0]           menu_mode;
    logic [TEMP_W-1:0]    temp_setting;
    logic [HOURS_W-1:0]   hours_count;
    logic [MINUTES_W-1:0] minutes_count;

    // one tick: countdown, debounce, menu and encoder, in that order
    task advance_tick(input logic press, input logic [1:0] step);
        logic [HOURS_W-1:0] limit;
        int nxt;
        status_t s;
        limit = (max_hours < HOURS_CAP) ? max_hours : HOURS_CAP;
        if (tick_phase == '0 && menu_mode == UI_IDLE)
        begin
            if (minutes_count != '0)
            begin
                minutes_count = minutes_count - 1'b1;
                countdown_steps++;
            end
            else if (hours_count != '0)
            begin
                minutes_count = MINUTES_TOP;
                hours_count = hours_count - 1'b1;
                countdown_steps++;
            end
        end
        case (button_phase)
            DB_NONE:           button_phase = press ? DB_MAYBE_PRESSED : DB_NONE;
            DB_MAYBE_PRESSED:  button_phase = press ? DB_PRESSED : DB_NONE;
            DB_PRESSED:        button_phase = press ? DB_PRESSED : DB_MAYBE_RELEASED;
            DB_MAYBE_RELEASED: button_phase = press ? DB_PRESSED : DB_RELEASED;
            default:           button_phase = press ? DB_MAYBE_PRESSED : DB_NONE;
        endcase
        if (button_phase == DB_RELEASED)
        begin
            if (menu_mode == UI_IDLE)
                menu_mode = UI_TEMP;
            else if (menu_mode == UI_TEMP)
                menu_mode = UI_HOURS;
            else
                menu_mode = UI_IDLE;
            menu_moves++;
        end
        if (step == STEP_UP)
        begin
            if (menu_mode == UI_TEMP && temp_setting < TEMP_MAX)
                temp_setting = temp_setting + 1'b1;
            else if (menu_mode == UI_HOURS && hours_count < limit)
                hours_count = hours_count + 1'b1;
        end
        else if (step == STEP_DOWN)
        begin
            if (menu_mode == UI_TEMP && temp_setting != '0)
                temp_setting = temp_setting - 1'b1;
            else if (menu_mode == UI_HOURS && hours_count != '0)
                hours_count = hours_count - 1'b1;
        end
        // a zero count behaves as one, a lowered count wraps at once
        nxt = int'(tick_phase) + 1;
        tick_phase = (nxt >= int'(ticks_per_count)) ? '0 : nxt[TICK_W-1:0];
        s.mode    = menu_mode;
        s.temp    = temp_setting;
        s.hours   = hours_count;
        s.minutes = minutes_count;
        s.phase   = button_phase;
        s.running = (hours_count != '0) || (minutes_count != '0);
        due_status.push_back(s);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t got;
        status_t want;
        if (!rst_n)
        begin
            due_status.delete();
            ticks_per_count = TICKS_RESET;
            max_hours       = MAX_HOURS_RESET;
            tick_phase      = '0;
            button_phase    = DB_NONE;
            menu_mode       = UI_IDLE;
            temp_setting    = TEMP_RESET;
            hours_count     = '0;
            minutes_count   = '0;
            errors          = 0;
            checked         = 0;
            menu_moves      = 0;
            countdown_steps = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {ui_mode, target_temp, hours_left, minutes_left, debounce_phase,
                       countdown_running};
                if (due_status.size() == 0)
                begin
                    $error("status item arrived with nothing expected");
                    errors++;
                end
                else
                begin
                    want = due_status.pop_front();
                    checked++;
                    if (got.mode !== want.mode)
                    begin
                        $error("ui_mode: expected %0d, got %0d", want.mode, got.mode);
                        errors++;
                    end
                    if (got.temp !== want.temp)
                    begin
                        $error("target_temp: expected %0d, got %0d", want.temp, got.temp);
                        errors++;
                    end
                    if (got.hours !== want.hours)
                    begin
                        $error("hours_left: expected %0d, got %0d", want.hours, got.hours);
                        errors++;
                    end
                    if (got.minutes !== want.minutes)
                    begin
                        $error("minutes_left: expected %0d, got %0d", want.minutes,
                               got.minutes);
                        errors++;
                    end
                    if (got.phase !== want.phase)
                    begin
                        $error("debounce_phase: expected %0d, got %0d", want.phase,
                               got.phase);
                        errors++;
                    end
                    if (got.running !== want.running)
                    begin
                        $error("countdown_running: expected %0d, got %0d", want.running,
                               got.running);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                advance_tick(button_level, encoder_step);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TICKS_PER_COUNT: ticks_per_count = cfg_data[TICK_W-1:0];
                    CFG_MAX_HOURS:       max_hours = cfg_data[HOURS_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = due_status.size();
    end

endmodule

FILE: tb/tb.sv
// testbench top: drives ticks and register writes into the controller and gives the verdict
`timescale 1ns / 1ps
module tb;
    import kmcc_pkg::*;

    localparam logic [1:0] STEP_NONE  = 2'd0;
    localparam logic [1:0] STEP_SPARE = 2'd3;
    localparam int         PHASES     = 7;
    localparam int         PHASE_TICKS = 180;
    localparam int         WATCH_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  button_level = 1'b0;
    logic [1:0]            encoder_step = STEP_NONE;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            ui_mode;
    logic [TEMP_W-1:0]     target_temp;
    logic [HOURS_W-1:0]    hours_left;
    logic [MINUTES_W-1:0]  minutes_left;
    logic [2:0]            debounce_phase;
    logic                  countdown_running;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TICKS_PER_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors, pending, checked, menu_moves, countdown_steps;
    int ticks_sent = 0;
    int settings_used = 1;
    int idle_cycles = 0;
    int stall_left = 0;
    bit out_calm = 1'b0;
    bit in_calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    knob_menu_countdown_controller_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .button_level(button_level), .encoder_step(encoder_step),
        .out_valid(out_valid), .out_stall(out_stall),
        .ui_mode(ui_mode), .target_temp(target_temp), .hours_left(hours_left),
        .minutes_left(minutes_left), .debounce_phase(debounce_phase),
        .countdown_running(countdown_running),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    kmcc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .button_level(button_level), .encoder_step(encoder_step),
        .out_valid(out_valid), .out_stall(out_stall),
        .ui_mode(ui_mode), .target_temp(target_temp), .hours_left(hours_left),
        .minutes_left(minutes_left), .debounce_phase(debounce_phase),
        .countdown_running(countdown_running),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked),
        .menu_moves(menu_moves), .countdown_steps(countdown_steps)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 40);
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_tick(input logic level, input logic [1:0] step);
        int gap;
        gap = (in_calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        button_level <= level;
        encoder_step <= step;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        ticks_sent++;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 63) == 0)
                out_calm <= !out_calm;
            if (!out_calm && $urandom_range(0, 3) == 0)
                stall_left <= gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int quota;
        int kind;
        int len;
        int tpc;
        int mh;
        logic [1:0] dir;
        logic level;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // encoder ignored while idle, code three is no step, countdown stays at 00:00
        send_tick(1'b0, STEP_UP);
        send_tick(1'b0, STEP_DOWN);
        send_tick(1'b0, STEP_SPARE);
        // one-tick glitch falls back to none
        send_tick(1'b1, STEP_NONE);
        send_tick(1'b0, STEP_NONE);
        // clean click into temperature, step on the release tick
        send_tick(1'b1, STEP_NONE);
        send_tick(1'b1, STEP_NONE);
        send_tick(1'b1, STEP_UP);
        send_tick(1'b0, STEP_UP);
        send_tick(1'b0, STEP_UP);
        send_tick(1'b0, STEP_DOWN);
        send_tick(1'b0, STEP_SPARE);
        // release bounce goes back to pressed, then into hours
        send_tick(1'b1, STEP_NONE);
        send_tick(1'b1, STEP_NONE);
        send_tick(1'b0, STEP_NONE);
        send_tick(1'b1, STEP_NONE);
        send_tick(1'b0, STEP_NONE);
        send_tick(1'b0, STEP_UP);
        // press straight after the released tick, back to idle
        send_tick(1'b1, STEP_UP);
        send_tick(1'b1, STEP_NONE);
        send_tick(1'b0, STEP_NONE);
        send_tick(1'b0, STEP_DOWN);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                in_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
                repeat (3) @(negedge clk);
                case (ph)
                    1:
                    begin
                        tpc = 1;
                        mh  = 99;
                    end
                    2:
                    begin
                        tpc = 0;
                        mh  = 127;
                    end
                    3:
                    begin
                        tpc = 65535;
                        mh  = 0;
                    end
                    4:
                    begin
                        tpc = 1;
                        mh  = 1;
                    end
                    5:
                    begin
                        tpc = 3;
                        mh  = 5;
                    end
                    default:
                    begin
                        tpc = $urandom_range(2, 200);
                        mh  = $urandom_range(0, 127);
                    end
                endcase
                cfg_valid <= 1'b1;
                cfg_index <= CFG_TICKS_PER_COUNT;
                cfg_data  <= tpc[CFG_DATA_W-1:0];
                do
                    @(posedge clk);
                while (!cfg_ready);
                @(negedge clk);
                // junk above the seven hours bits is dropped
                cfg_index <= CFG_MAX_HOURS;
                cfg_data  <= {9'($urandom_range(0, 511)), mh[HOURS_W-1:0]};
                do
                    @(posedge clk);
                while (!cfg_ready);
                @(negedge clk);
                cfg_valid <= 1'b0;
                settings_used++;
            end
            quota = ticks_sent + PHASE_TICKS;
            while (ticks_sent < quota)
            begin
                if ($urandom_range(0, 15) == 0)
                    in_calm = !in_calm;
                kind = $urandom_range(0, 99);
                if (kind < 30)
                begin
                    // clean click with random encoder activity
                    len = $urandom_range(2, 6);
                    repeat (len) send_tick(1'b1, 2'($urandom_range(0, 3)));
                    len = $urandom_range(2, 4);
                    repeat (len) send_tick(1'b0, 2'($urandom_range(0, 3)));
                end
                else if (kind < 65)
                begin
                    // encoder burst in one direction, long ones reach the limits
                    dir = $urandom_range(0, 1) ? STEP_UP : STEP_DOWN;
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                                                      : $urandom_range(1, 8);
                    repeat (len)
                        send_tick(1'b0, ($urandom_range(0, 9) == 0)
                                        ? 2'($urandom_range(0, 3)) : dir);
                end
                else if (kind < 85)
                begin
                    // quiet run so the countdown can move
                    len = $urandom_range(1, 40);
                    repeat (len) send_tick(1'b0, STEP_NONE);
                end
                else
                begin
                    len = $urandom_range(1, 10);
                    repeat (len)
                    begin
                        level = 1'($urandom_range(0, 1));
                        send_tick(level, 2'($urandom_range(0, 3)));
                    end
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("%0d ticks over %0d register settings, %0d status items checked",
                 ticks_sent, settings_used, checked);
        $display("%0d menu steps and %0d countdown steps predicted", menu_moves,
                 countdown_steps);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
